// File: rtl/core/two_pkg.sv
// Shared types and constants for the tracking wheel odometry block.
// No dependencies; every other file depends on this package.
package two_pkg;

    typedef struct packed {
        logic signed [15:0] x_count_delta;
        logic signed [15:0] y_count_delta;
        logic [15:0]        heading;
        logic               heading_fresh;
    } two_in_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic               applied;
        logic               saturated;
    } two_out_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_X_SCALE  = 2'd0;
    localparam logic [1:0] REG_Y_SCALE  = 2'd1;
    localparam logic [1:0] REG_X_OFFSET = 2'd2;
    localparam logic [1:0] REG_Y_OFFSET = 2'd3;

    // Datapath operations chosen by the controller.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_WHEEL  = 4'd2;
    localparam logic [3:0] OP_RAD    = 4'd3;
    localparam logic [3:0] OP_OFFX   = 4'd4;
    localparam logic [3:0] OP_OFFY   = 4'd5;
    localparam logic [3:0] OP_BODY   = 4'd6;
    localparam logic [3:0] OP_CORDIC = 4'd7;
    localparam logic [3:0] OP_QUAD   = 4'd8;
    localparam logic [3:0] OP_ROT0   = 4'd9;
    localparam logic [3:0] OP_ROT1   = 4'd10;
    localparam logic [3:0] OP_STEP   = 4'd11;
    localparam logic [3:0] OP_ACC    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] iter;
    } two_cmd_t;

    localparam int          ATAN_LEN     = 24;
    localparam logic [63:0] TWO_PI_Q29   = 64'd3373259426;
    localparam logic [31:0] GAIN_Q30     = 32'd652032874;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F;
                5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B;
                5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/core/two_datapath.sv
// Odometry datapath: wheel scaling, heading change, CORDIC and accumulators.
// Depends on two_pkg; sequenced by two_control.
module two_datapath #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  two_pkg::two_cmd_t  cmd,
    input  two_pkg::two_in_t   in_item,
    input  logic [31:0]        x_scale,
    input  logic [31:0]        y_scale,
    input  logic [31:0]        x_offset,
    input  logic [31:0]        y_offset,
    output two_pkg::two_out_t  result
);
    import two_pkg::*;

    localparam int QS = ANGLE_BITS - 2;

    logic signed [15:0] cx_reg, cy_reg;
    logic [15:0]        h_reg;
    logic               fresh_reg;
    logic [15:0]        last_heading_reg;
    logic               heading_valid_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] stx_reg, sty_reg;
    logic               clip_reg;
    logic signed [17:0] d_reg;
    logic signed [47:0] dxw_reg, dyw_reg;
    logic signed [31:0] rad_reg;
    logic signed [63:0] offx_reg, offy_reg;
    logic signed [31:0] dxb_reg, dyb_reg;
    logic signed [33:0] cx_c_reg, cy_c_reg;
    logic signed [ANGLE_BITS:0] z_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic signed [66:0] p0_reg, p1_reg, p2_reg, p3_reg;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -68'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic ovf(input logic signed [67:0] v);
        return (v > 68'sd2147483647) || (v < -68'sd2147483648);
    endfunction

    logic [15:0]        dh;
    logic [ANGLE_BITS-1:0] ang;
    logic signed [ANGLE_BITS:0] step_a;
    logic signed [33:0] sx, sy;
    logic signed [67:0] sum0, sum1, ax, ay, bx, by;

    always_comb
    begin
        dh = in_item.heading - last_heading_reg;
        if (ANGLE_BITS >= 16)
            ang = ANGLE_BITS'({h_reg, {(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){1'b0}}}
                  >> (ANGLE_BITS > 16 ? 0 : 1));
        else
            ang = ANGLE_BITS'(h_reg >> (16 - ANGLE_BITS));
        step_a = (ANGLE_BITS + 1)'(atan_turns(cmd.iter) >> (32 - ANGLE_BITS));
        sx = cy_c_reg >>> cmd.iter;
        sy = cx_c_reg >>> cmd.iter;
        sum0 = 68'(p0_reg) - 68'(p1_reg);
        sum1 = 68'(p2_reg) + 68'(p3_reg);
        ax = 68'(stx_reg) + 68'(acc_x_reg);
        ay = 68'(sty_reg) + 68'(acc_y_reg);
        bx = 68'(dxw_reg) + 68'(offx_reg >>> 24);
        by = 68'(dyw_reg) - 68'(offy_reg >>> 24);
    end

    // One operation per command from the controller.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heading_reg  <= '0;
            heading_valid_reg <= 1'b0;
            acc_x_reg         <= '0;
            acc_y_reg         <= '0;
            fresh_reg         <= 1'b0;
            clip_reg          <= 1'b0;
            stx_reg           <= '0;
            sty_reg           <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    cx_reg    <= in_item.x_count_delta;
                    cy_reg    <= in_item.y_count_delta;
                    h_reg     <= in_item.heading;
                    fresh_reg <= in_item.heading_fresh;
                    clip_reg  <= 1'b0;
                    stx_reg   <= '0;
                    sty_reg   <= '0;
                    if (in_item.heading_fresh)
                    begin
                        d_reg <= heading_valid_reg ? 18'(signed'(dh)) : '0;
                        last_heading_reg  <= in_item.heading;
                        heading_valid_reg <= 1'b1;
                    end
                end
                OP_WHEEL:
                begin
                    dxw_reg <= (48'(cx_reg) * 48'(signed'(x_scale))) >>> 8;
                    dyw_reg <= (48'(cy_reg) * 48'(signed'(y_scale))) >>> 8;
                end
                OP_RAD:
                    rad_reg <= 32'((64'(d_reg) * signed'(TWO_PI_Q29)) >>> 21);
                OP_OFFX:
                    offx_reg <= 64'(signed'(x_offset)) * 64'(rad_reg);
                OP_OFFY:
                    offy_reg <= 64'(signed'(y_offset)) * 64'(rad_reg);
                OP_BODY:
                begin
                    dxb_reg  <= sat32(bx);
                    dyb_reg  <= sat32(by);
                    cx_c_reg <= 34'(GAIN_Q30);
                    cy_c_reg <= '0;
                    z_reg    <= (ANGLE_BITS + 1)'(ang[QS-1:0]);
                end
                OP_CORDIC:
                begin
                    if (!z_reg[ANGLE_BITS])
                    begin
                        cx_c_reg <= cx_c_reg - sx;
                        cy_c_reg <= cy_c_reg + sy;
                        z_reg    <= z_reg - step_a;
                    end
                    else
                    begin
                        cx_c_reg <= cx_c_reg + sx;
                        cy_c_reg <= cy_c_reg - sy;
                        z_reg    <= z_reg + step_a;
                    end
                end
                OP_QUAD:
                begin
                    case (ang[ANGLE_BITS-1 -: 2])
                        2'd0:    begin cos_reg <= cx_c_reg;  sin_reg <= cy_c_reg;  end
                        2'd1:    begin cos_reg <= -cy_c_reg; sin_reg <= cx_c_reg;  end
                        2'd2:    begin cos_reg <= -cx_c_reg; sin_reg <= -cy_c_reg; end
                        default: begin cos_reg <= cy_c_reg;  sin_reg <= -cx_c_reg; end
                    endcase
                end
                OP_ROT0:
                begin
                    p0_reg <= 67'(dxb_reg) * 67'(cos_reg);
                    p1_reg <= 67'(dyb_reg) * 67'(sin_reg);
                end
                OP_ROT1:
                begin
                    p2_reg <= 67'(dxb_reg) * 67'(sin_reg);
                    p3_reg <= 67'(dyb_reg) * 67'(cos_reg);
                end
                OP_STEP:
                begin
                    stx_reg <= sat32(sum0 >>> 30);
                    sty_reg <= sat32(sum1 >>> 30);
                end
                OP_ACC:
                begin
                    acc_x_reg <= sat32(ax);
                    acc_y_reg <= sat32(ay);
                    clip_reg  <= ovf(ax) | ovf(ay);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result = '{position_x: acc_x_reg, position_y: acc_y_reg,
                      step_x: stx_reg, step_y: sty_reg,
                      applied: fresh_reg, saturated: clip_reg};

endmodule

// File: rtl/core/two_control.sv
// Odometry sequencer: accepts an item, steps the datapath, holds the result.
// Depends on two_pkg; drives two_datapath.
module two_control #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_fresh,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output two_pkg::two_cmd_t cmd
);
    import two_pkg::*;

    localparam int NSTG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WHEEL = 4'd1;
    localparam logic [3:0] S_RAD = 4'd2;
    localparam logic [3:0] S_OFFX = 4'd3;
    localparam logic [3:0] S_OFFY = 4'd4;
    localparam logic [3:0] S_BODY = 4'd5;
    localparam logic [3:0] S_CORDIC = 4'd6;
    localparam logic [3:0] S_QUAD = 4'd7;
    localparam logic [3:0] S_ROT0 = 4'd8;
    localparam logic [3:0] S_ROT1 = 4'd9;
    localparam logic [3:0] S_STEP = 4'd10;
    localparam logic [3:0] S_ACC = 4'd11;
    localparam logic [3:0] S_OUT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] iter_reg, iter_next;

    // Idle takes a new transaction; the result waits in the output state.
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd.op     = OP_NONE;
        cmd.iter   = iter_reg;
        in_stall   = (state_reg != S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = in_fresh ? S_WHEEL : S_OUT;
                end
            S_WHEEL: begin cmd.op = OP_WHEEL; state_next = S_RAD; end
            S_RAD:   begin cmd.op = OP_RAD;   state_next = S_OFFX; end
            S_OFFX:  begin cmd.op = OP_OFFX;  state_next = S_OFFY; end
            S_OFFY:  begin cmd.op = OP_OFFY;  state_next = S_BODY; end
            S_BODY:
            begin
                cmd.op     = OP_BODY;
                iter_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op    = OP_CORDIC;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(NSTG - 1))
                    state_next = S_QUAD;
            end
            S_QUAD:  begin cmd.op = OP_QUAD; state_next = S_ROT0; end
            S_ROT0:  begin cmd.op = OP_ROT0; state_next = S_ROT1; end
            S_ROT1:  begin cmd.op = OP_ROT1; state_next = S_STEP; end
            S_STEP:  begin cmd.op = OP_STEP; state_next = S_ACC; end
            S_ACC:   begin cmd.op = OP_ACC;  state_next = S_OUT; end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

// File: rtl/core/tracking_wheel_odometry.sv
// Two tracking wheel dead-reckoning odometry, one result per encoder sample.
// With a fresh heading an accepted transaction steps through the wheel, radian,
// X offset, Y offset, body, CORDIC (CORDIC_STAGES of them, at most 24 run),
// quadrant, two rotate, step and accumulate states before its result is offered;
// with a stale heading it is offered in the next cycle. The result is held while
// the output stalls; after it is taken the block returns to idle, where the next
// transaction can be accepted. The iterative CORDIC, one stage per cycle, makes up
// most of that sequence. One transaction is in flight.
// Depends on two_pkg, two_control and two_datapath.
module tracking_wheel_odometry #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  two_pkg::two_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output two_pkg::two_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import two_pkg::*;

    logic [31:0] x_scale_reg, y_scale_reg, x_offset_reg, y_offset_reg;
    two_cmd_t    cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg  <= '0;
            y_scale_reg  <= '0;
            x_offset_reg <= '0;
            y_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_SCALE:  x_scale_reg  <= cfg_data;
                REG_Y_SCALE:  y_scale_reg  <= cfg_data;
                REG_X_OFFSET: x_offset_reg <= cfg_data;
                REG_Y_OFFSET: y_offset_reg <= cfg_data;
                default:      x_scale_reg  <= x_scale_reg;
            endcase
        end
    end

    two_control #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_fresh(in_data.heading_fresh), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
    );

    two_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data),
        .x_scale(x_scale_reg), .y_scale(y_scale_reg),
        .x_offset(x_offset_reg), .y_offset(y_offset_reg),
        .result(out_data)
    );

endmodule

// File: rtl/core/two_checker.sv
// Port-level checks for the odometry block, bound to its top level.
// Depends on two_pkg and tracking_wheel_odometry.
module two_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input two_pkg::two_out_t out_data
);
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No new transaction is taken while a result is offered.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // A skipped sample reports no step.
    a_stale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.applied |-> out_data.step_x == 0 && out_data.step_y == 0
        && !out_data.saturated)
        else $error("stale sample reported a step");

    // An accepted transaction keeps the input stalled in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");
endmodule

bind tracking_wheel_odometry two_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
